// ===== rtl/carstat_pkg.sv =====
// Package for the CIGAR aligned-region statistics unit.
// Holds the operation codes, the transaction structs and the saturating adder.
// No dependencies.
package carstat_pkg;

    // Operation kind codes; anything else counts as "other"
    localparam logic [2:0] KIND_MATCH    = 3'd0;
    localparam logic [2:0] KIND_MISMATCH = 3'd1;
    localparam logic [2:0] KIND_INSERT   = 3'd2;
    localparam logic [2:0] KIND_DELETE   = 3'd3;
    localparam logic [2:0] KIND_OTHER    = 3'd4;

    localparam int unsigned LEN_W   = 28;
    localparam int unsigned COUNT_W = 32;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // One CIGAR operation
    typedef struct packed {
        logic [2:0]       op_kind;
        logic [LEN_W-1:0] run_length;
        logic             last_op;
    } t_in_item;

    // One statistics result
    typedef struct packed {
        logic [COUNT_W-1:0] match_count;
        logic [COUNT_W-1:0] mismatch_count;
        logic [COUNT_W-1:0] region_columns;
        logic [COUNT_W-1:0] lead_query_bases;
        logic [COUNT_W-1:0] lead_subject_bases;
        logic [COUNT_W-1:0] lead_columns;
        logic               count_overflow;
    } t_out_item;

    // Saturating add: bit COUNT_W flags saturation, low bits hold the clamped sum
    function automatic logic [COUNT_W:0] sat_add(input logic [COUNT_W-1:0] a,
                                                 input logic [COUNT_W-1:0] b);
        logic [COUNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s[COUNT_W]) begin
            return {1'b1, COUNT_MAX};
        end
        return s;
    endfunction

endpackage

// ===== rtl/cigar_aligned_region_stats_unit.sv =====
// Top level of the CIGAR aligned-region statistics unit.
// Input register, accumulators and result register; uses carstat_pkg.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_item) takes one CIGAR
//   operation per transaction: kind, run length and a last-operation flag.
//   Output channel (o_out_valid / i_out_stall / o_out_item) gives one result
//   per CIGAR, built from the operation flagged last.
//   An accepted operation lands in the input register and is folded into
//   the accumulators at the edge that takes it out of that register; for a
//   last operation the result is loaded into the result register and
//   o_out_valid rises at that edge. All accumulators clear at that edge.
//   Throughput is one operation per cycle while no last operation is held,
//   set by the accumulator update (a chain of two 32-bit saturating adds
//   on the region count). Operations without the last flag keep flowing while
//   a result waits; a last operation waits in the input register only while the
//   result register is full and stalled, and then o_in_stall is high.
//   Reset (i_rst_n low, synchronous) empties both registers and clears all
//   counts and the overflow flag.
module cigar_aligned_region_stats_unit (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  carstat_pkg::t_in_item  i_in_item,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output carstat_pkg::t_out_item o_out_item
);

    localparam int unsigned CW = carstat_pkg::COUNT_W;

    // Input register
    logic                  r_in_valid;
    carstat_pkg::t_in_item r_in;

    // Accumulators
    logic          r_seen;
    logic [CW-1:0] r_matches;
    logic [CW-1:0] r_mismatches;
    logic [CW-1:0] r_region;
    logic [CW-1:0] r_pending;
    logic [CW-1:0] r_lead_cols;
    logic [CW-1:0] r_lead_query;
    logic [CW-1:0] r_lead_subj;
    logic          r_ovf;

    // Result register
    logic                   r_out_valid;
    carstat_pkg::t_out_item r_out;

    logic          w_blocked;
    logic          w_fire;
    logic          w_aligned;
    logic          w_is_match;
    logic          w_is_ins;
    logic          w_is_del;
    logic [CW-1:0] w_len;
    logic [CW-1:0] w_gap;
    logic [CW:0]   s_gap;
    logic [CW:0]   s_region;
    logic [CW:0]   s_match;
    logic [CW:0]   s_mis;
    logic [CW:0]   s_pend;
    logic [CW:0]   s_lead;
    logic [CW:0]   s_lq;
    logic [CW:0]   s_ls;

    logic          n_seen;
    logic [CW-1:0] n_matches;
    logic [CW-1:0] n_mismatches;
    logic [CW-1:0] n_region;
    logic [CW-1:0] n_pending;
    logic [CW-1:0] n_lead_cols;
    logic [CW-1:0] n_lead_query;
    logic [CW-1:0] n_lead_subj;
    logic          n_ovf;
    carstat_pkg::t_out_item n_out;

    // Handshake: a last op waits only while the result register is held
    assign w_blocked   = r_in.last_op && r_out_valid && i_out_stall;
    assign w_fire      = r_in_valid && !w_blocked;
    assign o_in_stall  = r_in_valid && w_blocked;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Kind decode; unused codes fall through as "other"
    assign w_is_match = (r_in.op_kind == carstat_pkg::KIND_MATCH);
    assign w_aligned  = w_is_match || (r_in.op_kind == carstat_pkg::KIND_MISMATCH);
    assign w_is_ins   = (r_in.op_kind == carstat_pkg::KIND_INSERT);
    assign w_is_del   = (r_in.op_kind == carstat_pkg::KIND_DELETE);
    assign w_len      = {{(CW - carstat_pkg::LEN_W){1'b0}}, r_in.run_length};
    assign w_gap      = r_seen ? r_pending : '0;

    // Candidate sums
    assign s_gap    = carstat_pkg::sat_add(r_region, w_gap);
    assign s_region = carstat_pkg::sat_add(s_gap[CW-1:0], w_len);
    assign s_match  = carstat_pkg::sat_add(r_matches, w_len);
    assign s_mis    = carstat_pkg::sat_add(r_mismatches, w_len);
    assign s_pend   = carstat_pkg::sat_add(r_pending, w_len);
    assign s_lead   = carstat_pkg::sat_add(r_lead_cols, w_len);
    assign s_lq     = carstat_pkg::sat_add(r_lead_query, w_len);
    assign s_ls     = carstat_pkg::sat_add(r_lead_subj, w_len);

    // Next accumulator values for the op in the input register
    always_comb begin
        n_seen       = r_seen;
        n_matches    = r_matches;
        n_mismatches = r_mismatches;
        n_region     = r_region;
        n_pending    = r_pending;
        n_lead_cols  = r_lead_cols;
        n_lead_query = r_lead_query;
        n_lead_subj  = r_lead_subj;
        n_ovf        = r_ovf;
        if (w_aligned) begin
            // region absorbs the gap since the previous aligned op
            n_seen    = 1'b1;
            n_region  = s_region[CW-1:0];
            n_pending = '0;
            n_ovf     = r_ovf || s_gap[CW] || s_region[CW];
            if (w_is_match) begin
                n_matches = s_match[CW-1:0];
                n_ovf     = n_ovf || s_match[CW];
            end else begin
                n_mismatches = s_mis[CW-1:0];
                n_ovf        = n_ovf || s_mis[CW];
            end
        end else if (r_seen) begin
            // trailing gap, saturates silently
            n_pending = s_pend[CW-1:0];
        end else begin
            // lead columns
            n_lead_cols = s_lead[CW-1:0];
            n_ovf       = r_ovf || s_lead[CW];
            if (w_is_ins) begin
                n_lead_query = s_lq[CW-1:0];
                n_ovf        = n_ovf || s_lq[CW];
            end else if (w_is_del) begin
                n_lead_subj = s_ls[CW-1:0];
                n_ovf       = n_ovf || s_ls[CW];
            end
        end
    end

    // Result assembly
    always_comb begin
        if (n_seen) begin
            n_out.match_count        = n_matches;
            n_out.mismatch_count     = n_mismatches;
            n_out.region_columns     = n_region;
            n_out.lead_query_bases   = n_lead_query;
            n_out.lead_subject_bases = n_lead_subj;
            n_out.lead_columns       = n_lead_cols;
        end else begin
            // no aligned op: the whole run is the region
            n_out.match_count        = '0;
            n_out.mismatch_count     = '0;
            n_out.region_columns     = n_lead_cols;
            n_out.lead_query_bases   = '0;
            n_out.lead_subject_bases = '0;
            n_out.lead_columns       = '0;
        end
        n_out.count_overflow = n_ovf;
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in <= i_in_item;
        end
    end

    // Accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_fire && r_in.last_op)) begin
            r_seen       <= 1'b0;
            r_matches    <= '0;
            r_mismatches <= '0;
            r_region     <= '0;
            r_pending    <= '0;
            r_lead_cols  <= '0;
            r_lead_query <= '0;
            r_lead_subj  <= '0;
            r_ovf        <= 1'b0;
        end else if (w_fire) begin
            r_seen       <= n_seen;
            r_matches    <= n_matches;
            r_mismatches <= n_mismatches;
            r_region     <= n_region;
            r_pending    <= n_pending;
            r_lead_cols  <= n_lead_cols;
            r_lead_query <= n_lead_query;
            r_lead_subj  <= n_lead_subj;
            r_ovf        <= n_ovf;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && r_in.last_op) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && r_in.last_op) begin
            r_out <= n_out;
        end
    end

`ifndef ASSERT_OFF
    // A finished CIGAR leaves every accumulator clear
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_in.last_op) |=> (!r_seen && !r_ovf && r_region == '0 &&
            r_matches == '0 && r_mismatches == '0 && r_pending == '0 &&
            r_lead_cols == '0 && r_lead_query == '0 && r_lead_subj == '0))
        else $error("accumulators not cleared after last op");

    // Lead counts freeze once the region has opened
    a_lead_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_seen && !r_in.last_op) |=>
            (r_lead_cols == $past(r_lead_cols) && r_lead_query == $past(r_lead_query) &&
             r_lead_subj == $past(r_lead_subj)))
        else $error("lead counts changed inside the region");

    // Overflow flag is sticky until the CIGAR ends
    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovf && !(w_fire && r_in.last_op)) |=> r_ovf)
        else $error("overflow flag lost mid-CIGAR");

    // A new result only appears when a last op was folded in
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!(w_fire && r_in.last_op) && !(r_out_valid && i_out_stall)) |=> !r_out_valid)
        else $error("result without a last op");
`endif

endmodule
